FILE: rtl/sbfr_pkg.sv
// shared types and constants for the start byte frame receiver
// no dependencies

package sbfr_pkg;

   localparam int PAYLOAD_BYTES_DEFAULT = 8;
   localparam int PAYLOAD_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] START_BYTE_RESET = 8'd64;
   localparam logic [8:0] TYPE_LIMIT_RESET = 9'd256;

   typedef enum logic {
      REG_START_BYTE = 1'b0,
      REG_TYPE_LIMIT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_TYPE    = 2'd2,
      PH_CHECK   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_CHECKSUM = 2'd1,
      ST_TYPE     = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [8:0] type_limit;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [PAYLOAD_W-1:0] payload;
      logic [7:0]           frame_type;
      status_type           frame_status;
   } result_type;

endpackage

FILE: rtl/sbfr_csr.sv
// configuration registers: start byte and type limit, apb-style access
// depends on sbfr_pkg

module sbfr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sbfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sbfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sbfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output sbfr_pkg::cfg_type               cfg
);
   import sbfr_pkg::*;

   logic [7:0]    start_ff;
   logic [8:0]    limit_ff;
   logic          wr_en;
   reg_index_type sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign sel = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_BYTE_RESET;
         limit_ff <= TYPE_LIMIT_RESET;
      end else if (wr_en) begin
         case (sel)
            REG_START_BYTE: start_ff <= csr_pwdata[7:0];
            REG_TYPE_LIMIT: limit_ff <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_START_BYTE: csr_prdata = CSR_DATA_W'(start_ff);
         REG_TYPE_LIMIT: csr_prdata = CSR_DATA_W'(limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.start_byte = start_ff;
   assign cfg.type_limit = limit_ff;

endmodule

FILE: rtl/sbfr_core.sv
// frame state machine, payload and type capture, running checksum
// depends on sbfr_pkg

module sbfr_core #(
   parameter int PAYLOAD_BYTES = sbfr_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  logic                 link_error,
   input  sbfr_pkg::cfg_type    cfg,
   output sbfr_pkg::result_type res
);
   import sbfr_pkg::*;

   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       sum_ff;
   logic [7:0]       type_ff;
   logic [7:0]       pl_ff [PAYLOAD_BYTES];
   logic             go;

   assign go = step & ~link_error;

   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (link_error) begin
            phase_in = PH_HUNT;
         end else begin
            case (phase_ff)
               PH_HUNT:    if (rx_byte == cfg.start_byte) phase_in = PH_PAYLOAD;
               PH_PAYLOAD: if (idx_ff == IDX_LAST) phase_in = PH_TYPE;
               PH_TYPE:    phase_in = PH_CHECK;
               PH_CHECK:   phase_in = PH_HUNT;
               default:    phase_in = PH_HUNT;
            endcase
         end
      end
   end

   always_comb begin
      res.valid = go & (phase_ff == PH_CHECK);
      res.frame_type = type_ff;
      res.payload = '0;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         res.payload[8*k +: 8] = pl_ff[k];
      end
      if (rx_byte != sum_ff) begin
         res.frame_status = ST_CHECKSUM;
      end else if ({1'b0, type_ff} >= cfg.type_limit) begin
         res.frame_status = ST_TYPE;
      end else begin
         res.frame_status = ST_GOOD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         if (step & (link_error | (phase_ff == PH_HUNT))) begin
            idx_ff <= '0;
         end else if (go & (phase_ff == PH_PAYLOAD)) begin
            idx_ff <= (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         case (phase_ff)
            PH_HUNT: sum_ff <= '0;
            PH_PAYLOAD: begin
               pl_ff[idx_ff] <= rx_byte;
               sum_ff        <= sum_ff + rx_byte;
            end
            PH_TYPE: begin
               type_ff <= rx_byte;
               sum_ff  <= sum_ff + rx_byte;
            end
            default: ;
         endcase
      end
   end

endmodule

FILE: rtl/start_byte_frame_receiver.sv
// Start byte frame receiver: hunts for the configured start byte, collects
// PAYLOAD_BYTES payload bytes, a type byte and a checksum byte, and emits one
// item per frame with payload, type and status. Takes one byte per cycle
// while not stalled; an item passes an input register, the frame logic and
// an output register, so rsp_tvalid is registered and rises once the frame
// logic takes the checksum byte from the input register. The input side
// stalls only while the output register holds an item that is not taken.
// Configuration reads and writes complete without wait states.
// depends on sbfr_pkg, sbfr_csr, sbfr_core

module start_byte_frame_receiver #(
   parameter int PAYLOAD_BYTES = sbfr_pkg::PAYLOAD_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // rx_byte
   input  logic                            req_tuser,  // link_error
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sbfr_pkg::PAYLOAD_W-1:0]  rsp_tdata,  // payload
   output logic [9:0]                      rsp_tuser,  // frame_type, frame_status
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sbfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sbfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sbfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import sbfr_pkg::*;

   cfg_type              cfg;
   result_type           res;
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_err_ff;
   logic                 out_valid_ff;
   logic [PAYLOAD_W-1:0] out_payload_ff;
   logic [7:0]           out_type_ff;
   status_type           out_status_ff;
   logic                 out_free;
   logic                 step;

   sbfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sbfr_core #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .link_error (in_err_ff),
      .cfg        (cfg),
      .res        (res)
   );

   assign out_free   = ~out_valid_ff | rsp_tready;
   assign step       = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         in_byte_ff <= req_tdata;
         in_err_ff  <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         out_payload_ff <= res.payload;
         out_type_ff    <= res.frame_type;
         out_status_ff  <= res.frame_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_payload_ff;
   assign rsp_tuser  = {out_status_ff, out_type_ff};

endmodule
